### src/pfcc_pkg.sv
// pfcc_pkg: shared constants, types and elaboration-time functions for the
// GF(929) check codeword encoder. No dependencies.
package pfcc_pkg;

   localparam int unsigned WORD_W          = 10;
   localparam int unsigned LEVEL_W         = 3;
   localparam int unsigned FIELD_P         = 929;
   localparam int unsigned ROOT_BASE       = 3;
   localparam int unsigned MAX_CHECK_LIMIT = 32;
   localparam int unsigned MAX_CHECK_DEF   = 32;
   // levels 0..5 have their own generator; 6 and 7 share the level 5 row
   localparam int unsigned TAB_LEVELS      = 6;
   localparam int unsigned ROW_SEL_W       = $clog2(TAB_LEVELS);
   localparam int unsigned COEF_IDX_W      = $clog2(MAX_CHECK_LIMIT + 1);
   localparam int unsigned PROD_W          = 2 * WORD_W;
   // 2^10 mod 929, used to fold the high part of a product back down
   localparam int unsigned FOLD_C          = (1 << WORD_W) % FIELD_P;
   // wide enough for the first fold of a 20 bit product
   localparam int unsigned FOLD_W          = 17;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [MAX_CHECK_LIMIT:0] gen_row_type;

   localparam word_type FIELD_P_W = WORD_W'(FIELD_P);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic shift;
      logic ins_calc;
      logic clear;
      logic emit;
      logic emit_last;
   } ctrl_type;

   // number of check words for a level, saturated to the line depth
   function automatic int unsigned level_count(input int unsigned level,
                                               input int unsigned max_check);
      int unsigned c;
      c = 0;
      if (level == 0) begin
         c = 0;
      end else if (level >= 6) begin
         c = max_check;
      end else begin
         c = 1 << level;
         if (c > max_check) begin
            c = max_check;
         end
      end
      return c;
   endfunction

   // coefficients of prod_{i=1..k}(x - 3^i) mod 929, leading term first
   function automatic gen_row_type gen_row(input int unsigned k);
      int unsigned g [MAX_CHECK_LIMIT+1];
      int unsigned p;
      gen_row_type row;
      p = 1;
      for (int unsigned n = 0; n <= MAX_CHECK_LIMIT; n++) begin
         g[n] = 0;
      end
      g[0] = 1;
      for (int unsigned i = 1; i <= k; i++) begin
         p = (p * ROOT_BASE) % FIELD_P;
         g[i] = 0;
         for (int unsigned j = i; j >= 1; j--) begin
            g[j] = (g[j] + FIELD_P - ((g[j-1] * p) % FIELD_P)) % FIELD_P;
         end
      end
      for (int unsigned n = 0; n <= MAX_CHECK_LIMIT; n++) begin
         row[n] = WORD_W'(g[n]);
      end
      return row;
   endfunction

endpackage

### src/pfcc_if.sv
// pfcc_req_if / pfcc_rsp_if: valid/ready channels for codeword requests and
// encoded results. Depends on pfcc_pkg.
interface pfcc_req_if;
   logic                      valid;
   logic                      ready;
   logic [pfcc_pkg::WORD_W-1:0] data_word;
   logic                      last_data;

   modport source (output valid, output data_word, output last_data, input ready);
   modport sink   (input valid, input data_word, input last_data, output ready);
endinterface

interface pfcc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pfcc_pkg::WORD_W-1:0] out_word;
   logic                      is_check;
   logic                      last_out;

   modport source (output valid, output out_word, output is_check, output last_out,
                   input ready);
   modport sink   (input valid, input out_word, input is_check, input last_out,
                   output ready);
endinterface

### src/prime_field_check_codeword_encoder.sv
// prime_field_check_codeword_encoder: top level of the GF(929) check codeword
// encoder. Depends on pfcc_pkg, pfcc_if, pfcc_mulmod, pfcc_line, pfcc_seq.
//
// Data codewords (values above 928 are reduced mod 929) are passed straight
// to the output while the remainder of the message polynomial times x^k by
// prod_{i=1..k}(x - 3^i) is kept in a MAX_CHECK deep shift line. With level 0
// a request needs no remainder pass. Otherwise each accepted request is
// followed by a pass in which the whole line rotates once through the single
// multiply-mod unit, one coefficient per cycle, and the next request waits
// for that pass. On the request flagged last the k = 2^level check words
// (saturated to MAX_CHECK) follow, highest order first, one per cycle while
// the output is taken; the final one carries last_out. Writing csr_wdata
// clears the remainder and any message in progress; write it only between
// messages.
module prime_field_check_codeword_encoder #(
   parameter int unsigned MAX_CHECK = pfcc_pkg::MAX_CHECK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   pfcc_req_if.sink                       req_ch,
   pfcc_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [pfcc_pkg::LEVEL_W-1:0]   csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_CHECK + 1);
   localparam int unsigned W     = pfcc_pkg::WORD_W;
   localparam int unsigned CW    = pfcc_pkg::COEF_IDX_W;

   localparam pfcc_pkg::gen_row_type GEN_TAB [pfcc_pkg::TAB_LEVELS] = '{
      pfcc_pkg::gen_row(pfcc_pkg::level_count(0, MAX_CHECK)),
      pfcc_pkg::gen_row(pfcc_pkg::level_count(1, MAX_CHECK)),
      pfcc_pkg::gen_row(pfcc_pkg::level_count(2, MAX_CHECK)),
      pfcc_pkg::gen_row(pfcc_pkg::level_count(3, MAX_CHECK)),
      pfcc_pkg::gen_row(pfcc_pkg::level_count(4, MAX_CHECK)),
      pfcc_pkg::gen_row(pfcc_pkg::level_count(5, MAX_CHECK))
   };

   localparam logic [CNT_W-1:0] K_TAB [8] = '{
      CNT_W'(pfcc_pkg::level_count(0, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(1, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(2, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(3, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(4, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(5, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(6, MAX_CHECK)),
      CNT_W'(pfcc_pkg::level_count(7, MAX_CHECK))
   };

   localparam logic [pfcc_pkg::LEVEL_W-1:0] TOP_LEVEL =
      pfcc_pkg::LEVEL_W'(pfcc_pkg::TAB_LEVELS - 1);

   logic [pfcc_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [CNT_W-1:0]               k;
   logic [pfcc_pkg::ROW_SEL_W-1:0] row_sel;
   logic [CW-1:0]                  coef_idx;
   pfcc_pkg::word_type             coef;

   pfcc_pkg::word_type t_ff, t_in;
   pfcc_pkg::word_type d_red, head, next, calc_val, neg_head;
   logic [W:0]         t_sum;

   logic               rsp_valid_ff, rsp_valid_in;
   pfcc_pkg::word_type rsp_word_ff, rsp_word_in;
   logic               rsp_check_ff, rsp_check_in;
   logic               rsp_last_ff, rsp_last_in;

   pfcc_pkg::ctrl_type ctrl;
   logic [CNT_W-1:0]   step;
   logic               ready;
   logic               accept;
   logic               out_free;

   assign k        = K_TAB[level_ff];
   assign row_sel  = pfcc_pkg::ROW_SEL_W'((level_ff > TOP_LEVEL) ? TOP_LEVEL : level_ff);
   assign coef_idx = (step < CNT_W'(MAX_CHECK)) ? (CW'(step) + CW'(1)) : '0;
   assign coef     = GEN_TAB[row_sel][coef_idx];

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = ready;
   assign accept       = req_ch.valid && ready;

   // reduce the incoming word and form t = d + r0
   always_comb begin
      d_red = (req_ch.data_word >= pfcc_pkg::FIELD_P_W) ?
              (req_ch.data_word - pfcc_pkg::FIELD_P_W) : req_ch.data_word;
      t_sum = {1'b0, d_red} + {1'b0, head};
      t_in  = t_ff;
      if (accept) begin
         t_in = (t_sum >= (W+1)'(pfcc_pkg::FIELD_P)) ?
                W'(t_sum - (W+1)'(pfcc_pkg::FIELD_P)) : t_sum[W-1:0];
      end
      neg_head = (head == '0) ? '0 : (pfcc_pkg::FIELD_P_W - head);
      level_in = csr_we ? csr_wdata : level_ff;
   end

   // output register, loaded by a passed-through word or a check word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_check_in = rsp_check_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = d_red;
         rsp_check_in = 1'b0;
         rsp_last_in  = (k == '0) && req_ch.last_data;
      end else if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = neg_head;
         rsp_check_in = 1'b1;
         rsp_last_in  = ctrl.emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_check_ff <= rsp_check_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_word = rsp_word_ff;
   assign rsp_ch.is_check = rsp_check_ff;
   assign rsp_ch.last_out = rsp_last_ff;

   pfcc_mulmod u_mulmod (
      .clock  (clock),
      .coef   (coef),
      .t_val  (t_ff),
      .addend (next),
      .diff   (calc_val)
   );

   pfcc_line #(
      .DEPTH (MAX_CHECK)
   ) u_line (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .calc_val (calc_val),
      .head     (head),
      .next     (next)
   );

   pfcc_seq #(
      .MAX_CHECK (MAX_CHECK),
      .CNT_W     (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_data),
      .out_free  (out_free),
      .csr_we    (csr_we),
      .k         (k),
      .req_ready (ready),
      .ctrl      (ctrl),
      .step      (step)
   );

endmodule

### src/pfcc_mulmod.sv
// pfcc_mulmod: shared multiply-mod unit, computes (a - c*t) mod 929 with a
// registered product. Depends on pfcc_pkg.
module pfcc_mulmod (
   input  logic                 clock,
   input  pfcc_pkg::word_type   coef,
   input  pfcc_pkg::word_type   t_val,
   input  pfcc_pkg::word_type   addend,
   output pfcc_pkg::word_type   diff
);

   localparam int unsigned W  = pfcc_pkg::WORD_W;
   localparam int unsigned PW = pfcc_pkg::PROD_W;
   localparam int unsigned FW = pfcc_pkg::FOLD_W;
   localparam logic [FW-1:0] FOLD = FW'(pfcc_pkg::FOLD_C);
   localparam logic [FW-1:0] P_F  = FW'(pfcc_pkg::FIELD_P);

   logic [PW-1:0]      prod_ff, prod_in;
   pfcc_pkg::word_type addend_ff, addend_in;
   logic [FW-1:0]      x1, x2, x3;
   pfcc_pkg::word_type red;
   logic [W:0]         wrap;

   assign prod_in   = PW'(coef) * PW'(t_val);
   assign addend_in = addend;

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      addend_ff <= addend_in;
   end

   // three folds of 2^10 == 95 bring the product below 2*929
   always_comb begin
      x1   = FW'(prod_ff[PW-1:W]) * FOLD + FW'(prod_ff[W-1:0]);
      x2   = FW'(x1[FW-1:W]) * FOLD + FW'(x1[W-1:0]);
      x3   = FW'(x2[FW-1:W]) * FOLD + FW'(x2[W-1:0]);
      red  = (x3 >= P_F) ? W'(x3 - P_F) : W'(x3);
      wrap = {1'b0, addend_ff} + (W+1)'(pfcc_pkg::FIELD_P) - {1'b0, red};
      diff = (addend_ff >= red) ? (addend_ff - red) : wrap[W-1:0];
   end

endmodule

### src/pfcc_line.sv
// pfcc_line: remainder shift line, one coefficient per tap, head at tap 0.
// Depends on pfcc_pkg.
module pfcc_line #(
   parameter int unsigned DEPTH = pfcc_pkg::MAX_CHECK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pfcc_pkg::ctrl_type ctrl,
   input  pfcc_pkg::word_type calc_val,
   output pfcc_pkg::word_type head,
   output pfcc_pkg::word_type next
);

   pfcc_pkg::word_type sr_ff [DEPTH];
   pfcc_pkg::word_type sr_in [DEPTH];

   always_comb begin
      sr_in = sr_ff;
      if (ctrl.clear) begin
         for (int j = 0; j < DEPTH; j++) begin
            sr_in[j] = '0;
         end
      end else if (ctrl.shift) begin
         for (int j = 0; j < DEPTH - 1; j++) begin
            sr_in[j] = sr_ff[j+1];
         end
         sr_in[DEPTH-1] = ctrl.ins_calc ? calc_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            sr_ff[j] <= '0;
         end
      end else begin
         sr_ff <= sr_in;
      end
   end

   assign head = sr_ff[0];
   assign next = sr_ff[1];

endmodule

### src/pfcc_seq.sv
// pfcc_seq: sequencer for the remainder update pass and check word output.
// Depends on pfcc_pkg.
module pfcc_seq #(
   parameter int unsigned MAX_CHECK = pfcc_pkg::MAX_CHECK_DEF,
   parameter int unsigned CNT_W     = $clog2(MAX_CHECK + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   input  logic               out_free,
   input  logic               csr_we,
   input  logic [CNT_W-1:0]   k,
   output logic               req_ready,
   output pfcc_pkg::ctrl_type ctrl,
   output logic [CNT_W-1:0]   step
);

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_CHECK);
   localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

   pfcc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic                accept;

   assign accept = req_valid && req_ready;
   assign step   = cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      unique case (state_ff)
         pfcc_pkg::ST_IDLE: begin
            if (accept) begin
               last_in = req_last;
               cnt_in  = '0;
               if (k != '0) begin
                  state_in = pfcc_pkg::ST_CALC;
               end
            end
         end
         pfcc_pkg::ST_CALC: begin
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = last_ff ? pfcc_pkg::ST_EMIT : pfcc_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ONE;
            end
         end
         pfcc_pkg::ST_EMIT: begin
            if (out_free) begin
               if (cnt_ff == k - ONE) begin
                  cnt_in   = '0;
                  state_in = pfcc_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + ONE;
               end
            end
         end
         default: begin
            state_in = pfcc_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
      if (csr_we) begin
         state_in = pfcc_pkg::ST_IDLE;
         cnt_in   = '0;
      end
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      ctrl.clear = csr_we;
      unique case (state_ff)
         pfcc_pkg::ST_IDLE: begin
            req_ready = out_free;
         end
         pfcc_pkg::ST_CALC: begin
            // the unit output is registered, so nothing real to insert at step 0
            ctrl.shift    = 1'b1;
            ctrl.ins_calc = (cnt_ff != '0);
         end
         pfcc_pkg::ST_EMIT: begin
            ctrl.shift     = out_free;
            ctrl.emit      = out_free;
            ctrl.emit_last = (cnt_ff == k - ONE);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfcc_pkg::ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule
